// File: rtl/otp_pkg.sv
// Package: types, constants and codes for the OTP white-balance gain block.
`timescale 1ns / 1ps
package otp_pkg;

    localparam int GAIN_WIDTH     = 16;
    localparam int RATIO_W        = 16;
    localparam int UNITY_SHIFT    = 10;
    localparam int Q1_W           = RATIO_W + UNITY_SHIFT;   // first quotient
    localparam int Q2_W           = Q1_W + RATIO_W;          // second quotient
    localparam int LATENCY        = Q1_W + Q2_W + 3;

    localparam logic [Q2_W-1:0]    UNITY_GAIN   = Q2_W'(32'h400);
    localparam logic [7:0]         FLAG_MASK    = 8'hC0;
    localparam logic [7:0]         FLAG_VALID   = 8'h40;
    localparam logic [RATIO_W-1:0] RG_TYP_RESET = 16'h026c;
    localparam logic [RATIO_W-1:0] BG_TYP_RESET = 16'h02ed;

    localparam logic CFG_RG_TYP = 1'b0;
    localparam logic CFG_BG_TYP = 1'b1;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOVALID = 2'd1,
        ST_ZERO    = 2'd2,
        ST_SAT     = 2'd3
    } t_status;

    typedef struct packed {
        logic [7:0]         flag_bank1;
        logic [7:0]         module_bank1;
        logic [RATIO_W-1:0] rg_bank1;
        logic [RATIO_W-1:0] bg_bank1;
        logic [7:0]         flag_bank0;
        logic [7:0]         module_bank0;
        logic [RATIO_W-1:0] rg_bank0;
        logic [RATIO_W-1:0] bg_bank0;
    } t_otp_in;

    typedef struct packed {
        logic [GAIN_WIDTH-1:0] red_gain;
        logic [GAIN_WIDTH-1:0] green_gain;
        logic [GAIN_WIDTH-1:0] blue_gain;
        logic        write_red;
        logic        write_green;
        logic        write_blue;
        logic [3:0]  module_ident;
        logic        bank_used;
        t_status     status;
    } t_otp_out;

    // Classification carried alongside the first divider.
    typedef struct packed {
        logic               novalid;
        logic               zero;
        logic [3:0]         mod_ident;
        logic               bank;
        logic               bg_lt;
        logic               rg_lt;
        logic [RATIO_W-1:0] rg;
        logic [RATIO_W-1:0] bg;
    } t_front_side;

    // Carried alongside the second divider.
    typedef struct packed {
        logic            novalid;
        logic            zero;
        logic [3:0]      mod_ident;
        logic            bank;
        logic            ll;
        logic            sel_b;
        logic [Q1_W-1:0] qb;
        logic [Q1_W-1:0] qr;
    } t_mid_side;

endpackage

// File: rtl/otp_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, several lanes.
`timescale 1ns / 1ps
module otp_div_pipe
    import otp_pkg::*;
#(
    parameter int NL = 1,
    parameter int NW = 26,
    parameter int DW = 16,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num [NL],
    input  logic [DW-1:0] i_den [NL],
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [NW-1:0] o_quot [NL],
    output logic [SW-1:0] o_side
);

    logic          r_val  [NW];
    logic [SW-1:0] r_side [NW];
    logic [NW-1:0] r_num  [NW][NL];
    logic [DW-1:0] r_den  [NW][NL];
    logic [DW-1:0] r_rem  [NW][NL];

    for (genvar k = 0; k < NW; k++) begin : g_stage
        logic          w_val;
        logic [SW-1:0] w_side;

        if (k == 0) begin : g_first
            assign w_val  = i_valid;
            assign w_side = i_side;
        end else begin : g_next
            assign w_val  = r_val[k-1];
            assign w_side = r_side[k-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_val[k] <= 1'b0;
            end else begin
                r_val[k] <= w_val;
            end
        end

        always_ff @(posedge i_clk) begin
            r_side[k] <= w_side;
        end

        for (genvar l = 0; l < NL; l++) begin : g_lane
            logic [NW-1:0] w_num;
            logic [DW-1:0] w_den;
            logic [DW-1:0] w_rem;
            logic [DW:0]   w_trial;
            logic          w_ge;
            logic [DW-1:0] n_rem;
            logic [NW-1:0] n_num;

            if (k == 0) begin : g_first
                assign w_num = i_num[l];
                assign w_den = i_den[l];
                assign w_rem = '0;
            end else begin : g_next
                assign w_num = r_num[k-1][l];
                assign w_den = r_den[k-1][l];
                assign w_rem = r_rem[k-1][l];
            end

            always_comb begin
                w_trial = {w_rem, w_num[NW-1]};
                w_ge    = (w_trial >= {1'b0, w_den});
                n_rem   = w_ge ? DW'(w_trial - {1'b0, w_den}) : w_trial[DW-1:0];
                n_num   = {w_num[NW-2:0], w_ge};
            end

            always_ff @(posedge i_clk) begin
                r_num[k][l] <= n_num;
                r_den[k][l] <= w_den;
                r_rem[k][l] <= n_rem;
            end
        end
    end

    assign o_valid = r_val[NW-1];
    assign o_side  = r_side[NW-1];
    for (genvar l = 0; l < NL; l++) begin : g_out
        assign o_quot[l] = r_num[NW-1][l];
    end

endmodule

// File: rtl/otp_front.sv
// Bank selection, ratio checks and first-divider operand set-up.
`timescale 1ns / 1ps
module otp_front
    import otp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  t_otp_in            i_in,
    input  logic [RATIO_W-1:0] i_rg_typ,
    input  logic [RATIO_W-1:0] i_bg_typ,
    output logic               o_valid,
    output logic [Q1_W-1:0]    o_num [2],
    output logic [RATIO_W-1:0] o_den [2],
    output t_front_side        o_side
);

    logic               r_val;
    logic [Q1_W-1:0]    r_num [2];
    logic [RATIO_W-1:0] r_den [2];
    t_front_side        r_side;

    logic               w_b1, w_b0;
    logic [RATIO_W-1:0] w_rg, w_bg;
    logic [7:0]         w_mod;
    t_front_side        n_side;
    logic [Q1_W-1:0]    n_num [2];
    logic [RATIO_W-1:0] n_den [2];

    always_comb begin
        w_b1 = ((i_in.flag_bank1 & FLAG_MASK) == FLAG_VALID);
        w_b0 = ((i_in.flag_bank0 & FLAG_MASK) == FLAG_VALID);
        w_rg  = w_b1 ? i_in.rg_bank1 : i_in.rg_bank0;
        w_bg  = w_b1 ? i_in.bg_bank1 : i_in.bg_bank0;
        w_mod = w_b1 ? i_in.module_bank1 : i_in.module_bank0;

        n_side.novalid   = !w_b1 && !w_b0;
        n_side.zero      = (w_rg == '0) || (w_bg == '0) || (i_rg_typ == '0) ||
                           (i_bg_typ == '0);
        n_side.mod_ident = w_mod[7:4];
        n_side.bank      = w_b1;
        n_side.bg_lt     = (w_bg < i_bg_typ);
        n_side.rg_lt     = (w_rg < i_rg_typ);
        n_side.rg        = w_rg;
        n_side.bg        = w_bg;

        // Lane 0 is blue, lane 1 red; both below typical inverts the ratios.
        if (n_side.bg_lt && n_side.rg_lt) begin
            n_num[0] = {i_bg_typ, UNITY_SHIFT'(0)};
            n_den[0] = w_bg;
            n_num[1] = {i_rg_typ, UNITY_SHIFT'(0)};
            n_den[1] = w_rg;
        end else begin
            n_num[0] = {w_bg, UNITY_SHIFT'(0)};
            n_den[0] = i_bg_typ;
            n_num[1] = {w_rg, UNITY_SHIFT'(0)};
            n_den[1] = i_rg_typ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val <= 1'b0;
        end else begin
            r_val <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_side   <= n_side;
        r_num[0] <= n_num[0];
        r_num[1] <= n_num[1];
        r_den[0] <= n_den[0];
        r_den[1] <= n_den[1];
    end

    assign o_valid = r_val;
    assign o_side  = r_side;
    assign o_num   = r_num;
    assign o_den   = r_den;

endmodule

// File: rtl/otp_awb_gain_calc_unit.sv
// Top level: OTP white-balance gain calculation pipeline.
//
// Usage: present both banks' calibration words on i_in and pulse i_start.
// o_busy is always low, so a transfer takes place on every cycle with
// i_start high; one new bank set may enter each clock.
// Each transfer yields one result on o_result, marked by o_done for one
// cycle. Throughput is one result per cycle.
// The latency is set by the two restoring dividers, one quotient bit per
// stage: 26 stages for the first ratio pair, 42 for the dependent gain,
// plus the front, multiply and output registers.
// Typical ratios are written through i_cfg_we / i_cfg_idx / i_cfg_data; the user
// must write them only while no transfer is in flight: the block does not enforce it.
// Synchronous reset clears all valid bits and restores the typical ratios;
// items in flight are dropped. The receiver cannot stall: o_done is a strobe.
`timescale 1ns / 1ps
module otp_awb_gain_calc_unit
    import otp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  t_otp_in            i_in,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [RATIO_W-1:0] i_cfg_data,
    output logic               o_done,
    output t_otp_out           o_result
);

    logic [RATIO_W-1:0] r_rg_typ, r_bg_typ;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rg_typ <= RG_TYP_RESET;
            r_bg_typ <= BG_TYP_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_RG_TYP: r_rg_typ <= i_cfg_data;
                CFG_BG_TYP: r_bg_typ <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_busy = 1'b0;

    // front stage
    logic               f_val;
    logic [Q1_W-1:0]    f_num [2];
    logic [RATIO_W-1:0] f_den [2];
    t_front_side        f_side;

    otp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_start),
        .i_in     (i_in),
        .i_rg_typ (r_rg_typ),
        .i_bg_typ (r_bg_typ),
        .o_valid  (f_val),
        .o_num    (f_num),
        .o_den    (f_den),
        .o_side   (f_side)
    );

    // first ratio pair
    logic            a_val;
    logic [Q1_W-1:0] a_quot [2];
    t_front_side     a_side;

    otp_div_pipe #(
        .NL (2),
        .NW (Q1_W),
        .DW (RATIO_W),
        .SW ($bits(t_front_side))
    ) u_div_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_val),
        .i_num   (f_num),
        .i_den   (f_den),
        .i_side  (f_side),
        .o_valid (a_val),
        .o_quot  (a_quot),
        .o_side  (a_side)
    );

    // pick the held channel and form the second numerator
    logic               r_m_val;
    logic [Q2_W-1:0]    r_m_num [1];
    logic [RATIO_W-1:0] r_m_den [1];
    t_mid_side          r_m_side;
    t_mid_side          n_m_side;
    logic [Q1_W-1:0]    w_g;
    logic [RATIO_W-1:0] w_t;
    logic [Q2_W-1:0]    n_m_num;
    logic [RATIO_W-1:0] n_m_den;

    always_comb begin
        n_m_side.novalid   = a_side.novalid;
        n_m_side.zero      = a_side.zero;
        n_m_side.mod_ident = a_side.mod_ident;
        n_m_side.bank      = a_side.bank;
        n_m_side.ll        = a_side.bg_lt && a_side.rg_lt;
        n_m_side.sel_b     = !a_side.bg_lt && (a_side.rg_lt || (a_quot[0] > a_quot[1]));
        n_m_side.qb        = a_quot[0];
        n_m_side.qr        = a_quot[1];
        w_g     = n_m_side.sel_b ? a_quot[0] : a_quot[1];
        w_t     = n_m_side.sel_b ? r_rg_typ : r_bg_typ;
        n_m_den = n_m_side.sel_b ? a_side.rg : a_side.bg;
        n_m_num = Q2_W'(w_g) * Q2_W'(w_t);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_val <= 1'b0;
        end else begin
            r_m_val <= a_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_side   <= n_m_side;
        r_m_num[0] <= n_m_num;
        r_m_den[0] <= n_m_den;
    end

    // dependent gain
    logic            b_val;
    logic [Q2_W-1:0] b_quot [1];
    t_mid_side       b_side;

    otp_div_pipe #(
        .NL (1),
        .NW (Q2_W),
        .DW (RATIO_W),
        .SW ($bits(t_mid_side))
    ) u_div_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_m_val),
        .i_num   (r_m_num),
        .i_den   (r_m_den),
        .i_side  (r_m_side),
        .o_valid (b_val),
        .o_quot  (b_quot),
        .o_side  (b_side)
    );

    // clamp, strobes and status
    localparam logic [Q2_W-1:0] MAX_GAIN = (Q2_W'(1) << GAIN_WIDTH) - Q2_W'(1);

    logic      r_done;
    t_otp_out  r_result;
    t_otp_out  n_result;
    logic [Q2_W-1:0] w_r, w_gg, w_b, c_r, c_g, c_b;
    logic      w_sat;

    always_comb begin
        if (b_side.ll) begin
            w_r  = Q2_W'(b_side.qr);
            w_gg = UNITY_GAIN;
            w_b  = Q2_W'(b_side.qb);
        end else if (b_side.sel_b) begin
            w_r  = b_quot[0];
            w_gg = Q2_W'(b_side.qb);
            w_b  = UNITY_GAIN;
        end else begin
            w_r  = UNITY_GAIN;
            w_gg = Q2_W'(b_side.qr);
            w_b  = b_quot[0];
        end
        c_r   = (w_r  > MAX_GAIN) ? MAX_GAIN : w_r;
        c_g   = (w_gg > MAX_GAIN) ? MAX_GAIN : w_gg;
        c_b   = (w_b  > MAX_GAIN) ? MAX_GAIN : w_b;
        w_sat = (w_r > MAX_GAIN) || (w_gg > MAX_GAIN) || (w_b > MAX_GAIN);

        n_result              = '0;
        if (b_side.novalid) begin
            n_result.status = ST_NOVALID;
        end else if (b_side.zero) begin
            n_result.module_ident = b_side.mod_ident;
            n_result.bank_used    = b_side.bank;
            n_result.status       = ST_ZERO;
        end else begin
            n_result.red_gain     = c_r[GAIN_WIDTH-1:0];
            n_result.green_gain   = c_g[GAIN_WIDTH-1:0];
            n_result.blue_gain    = c_b[GAIN_WIDTH-1:0];
            n_result.write_red    = (c_r > UNITY_GAIN);
            n_result.write_green  = (c_g > UNITY_GAIN);
            n_result.write_blue   = (c_b > UNITY_GAIN);
            n_result.module_ident = b_side.mod_ident;
            n_result.bank_used    = b_side.bank;
            n_result.status       = w_sat ? ST_SAT : ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= b_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result <= n_result;
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

// File: rtl/otp_chk.sv
// Port-level checker for the gain calculation block, with its bind.
`timescale 1ns / 1ps
module otp_chk
    import otp_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_start,
    input logic     o_busy,
    input logic     o_done,
    input t_otp_out o_result
);

    // a result only ever follows a transfer exactly one latency earlier
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start && !o_busy, LATENCY))
        else $error("result without matching transfer");

    a_novalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status == ST_NOVALID) |->
        (o_result.red_gain == '0 && o_result.green_gain == '0 &&
         o_result.blue_gain == '0 && !o_result.bank_used &&
         o_result.module_ident == '0))
        else $error("no-valid-bank result not cleared");

    a_unity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status == ST_OK) |->
        (o_result.red_gain == 16'h400 || o_result.green_gain == 16'h400 ||
         o_result.blue_gain == 16'h400))
        else $error("no channel held at unity");

    a_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status == ST_OK) |->
        (o_result.write_red   == (o_result.red_gain   > 16'h400) &&
         o_result.write_green == (o_result.green_gain > 16'h400) &&
         o_result.write_blue  == (o_result.blue_gain  > 16'h400)))
        else $error("write strobe disagrees with gain");

endmodule

bind otp_awb_gain_calc_unit otp_chk u_otp_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_start  (i_start),
    .o_busy   (o_busy),
    .o_done   (o_done),
    .o_result (o_result)
);

// File: test/tb_otp_awb_gain_calc_unit.sv
// Testbench for the OTP white-balance gain block: directed table, then random bank sets.
`timescale 1ns / 1ps
module tb_otp_awb_gain_calc_unit;
    import otp_pkg::*;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_start;
    logic               o_busy;
    t_otp_in            i_in;
    logic               i_cfg_we;
    logic               i_cfg_idx;
    logic [RATIO_W-1:0] i_cfg_data;
    logic               o_done;
    t_otp_out           o_result;

    otp_awb_gain_calc_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .o_busy     (o_busy),
        .i_in       (i_in),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_done     (o_done),
        .o_result   (o_result)
    );

    typedef struct {
        t_otp_in  bank_set;
        bit       typed;
        t_otp_out gains;
    } t_row;

    logic [15:0] rg_typ_m;
    logic [15:0] bg_typ_m;
    t_otp_out    gain_q[$];
    t_row        table_rows[$];
    bit          cur_typed;
    t_otp_out    cur_gains;
    int          n_errors;
    int          n_sets;
    int          n_results;
    int          n_status[4];

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // Expected gains for one bank set under the given typical ratios.
    function automatic t_otp_out calc_gains(t_otp_in s, logic [15:0] rgt, logic [15:0] bgt);
        t_otp_out        o;
        longint unsigned rg, bg, rt, bt, r, g, b, gb, gr, maxv;
        bit              sat;
        o = '0;
        sat = 1'b0;
        rt = rgt;
        bt = bgt;
        maxv = (64'd1 << 16) - 1;
        if ((s.flag_bank1 & FLAG_MASK) == FLAG_VALID) begin
            rg = s.rg_bank1; bg = s.bg_bank1;
            o.module_ident = s.module_bank1[7:4];
            o.bank_used = 1'b1;
        end else if ((s.flag_bank0 & FLAG_MASK) == FLAG_VALID) begin
            rg = s.rg_bank0; bg = s.bg_bank0;
            o.module_ident = s.module_bank0[7:4];
            o.bank_used = 1'b0;
        end else begin
            o.status = ST_NOVALID;
            return o;
        end
        if (rg == 0 || bg == 0 || rt == 0 || bt == 0) begin
            o.status = ST_ZERO;
            return o;
        end
        if (bg < bt) begin
            if (rg < rt) begin
                g = 1024; b = 1024 * bt / bg; r = 1024 * rt / rg;
            end else begin
                r = 1024; g = 1024 * rg / rt; b = g * bt / bg;
            end
        end else if (rg < rt) begin
            b = 1024; g = 1024 * bg / bt; r = g * rt / rg;
        end else begin
            gb = 1024 * bg / bt;
            gr = 1024 * rg / rt;
            if (gb > gr) begin
                b = 1024; g = gb; r = g * rt / rg;
            end else begin
                r = 1024; g = gr; b = g * bt / bg;
            end
        end
        if (r > maxv) begin r = maxv; sat = 1'b1; end
        if (g > maxv) begin g = maxv; sat = 1'b1; end
        if (b > maxv) begin b = maxv; sat = 1'b1; end
        o.red_gain = r[15:0];
        o.green_gain = g[15:0];
        o.blue_gain = b[15:0];
        o.write_red = r > 1024;
        o.write_green = g > 1024;
        o.write_blue = b > 1024;
        o.status = sat ? ST_SAT : ST_OK;
        return o;
    endfunction

    // Check results, then record a transfer; latency keeps the two apart.
    always @(posedge i_clk) begin
        t_otp_out want;
        if (i_rst_n && o_done) begin
            n_results++;
            n_status[o_result.status]++;
            if (gain_q.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("unexpected result %h", o_result);
            end else begin
                want = gain_q.pop_front();
                if (o_result.red_gain !== want.red_gain
                        || o_result.green_gain !== want.green_gain
                        || o_result.blue_gain !== want.blue_gain
                        || o_result.write_red !== want.write_red
                        || o_result.write_green !== want.write_green
                        || o_result.write_blue !== want.write_blue
                        || o_result.module_ident !== want.module_ident
                        || o_result.bank_used !== want.bank_used
                        || o_result.status !== want.status) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("mismatch: gains r/g/b exp %h/%h/%h got %h/%h/%h, wr exp %b%b%b got %b%b%b, id exp %h got %h, bank exp %b got %b, status exp %0d got %0d",
                            want.red_gain, want.green_gain, want.blue_gain,
                            o_result.red_gain, o_result.green_gain, o_result.blue_gain,
                            want.write_red, want.write_green, want.write_blue,
                            o_result.write_red, o_result.write_green, o_result.write_blue,
                            want.module_ident, o_result.module_ident,
                            want.bank_used, o_result.bank_used, want.status, o_result.status);
                end
            end
        end
        if (i_rst_n && i_start && !o_busy) begin
            n_sets++;
            gain_q.push_back(cur_typed ? cur_gains : calc_gains(i_in, rg_typ_m, bg_typ_m));
        end
    end

    task automatic cfg_write(logic idx, logic [15:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_RG_TYP) rg_typ_m = val;
        else bg_typ_m = val;
    endtask

    task automatic wait_drained();
        while (gain_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 8) @(posedge i_clk);
    endtask

    // Hold start high back to back unless a gap is drawn.
    task automatic send_set(t_otp_in s, bit typed, t_otp_out g);
        int gap;
        @(negedge i_clk);
        i_start <= 1'b1;
        i_in <= s;
        cur_typed <= typed;
        cur_gains <= g;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        case ($urandom_range(0, 19))
            0, 1, 2, 3: gap = $urandom_range(1, 3);
            4:          gap = $urandom_range(10, 80);
            default:    gap = 0;
        endcase
        if (gap != 0) begin
            @(negedge i_clk);
            i_start <= 1'b0;
            cur_typed <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    function automatic logic [15:0] rand_ratio(logic [15:0] typ);
        int v;
        case ($urandom_range(0, 19))
            0:             return 16'd0;
            1, 2:          return 16'($urandom_range(1, 8));
            3, 4, 5:       return 16'($urandom_range(0, 65535));
            6:             return 16'hFFFF;
            7:             return typ;
            default: begin
                v = int'(typ) + $urandom_range(0, 400) - 200;
                if (v < 1) v = 1;
                if (v > 65535) v = 65535;
                return 16'(v);
            end
        endcase
    endfunction

    function automatic logic [7:0] rand_flag();
        logic [7:0] f;
        f = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 3) != 0) f[7:6] = 2'b01;
        return f;
    endfunction

    function automatic t_otp_in rand_set();
        t_otp_in s;
        s.flag_bank1 = rand_flag();
        s.flag_bank0 = rand_flag();
        s.module_bank1 = 8'($urandom_range(0, 255));
        s.module_bank0 = 8'($urandom_range(0, 255));
        s.rg_bank1 = rand_ratio(rg_typ_m);
        s.bg_bank1 = rand_ratio(bg_typ_m);
        s.rg_bank0 = rand_ratio(rg_typ_m);
        s.bg_bank0 = rand_ratio(bg_typ_m);
        return s;
    endfunction

    task automatic add_row(logic [7:0] f1, logic [7:0] m1, logic [15:0] rg1, logic [15:0] bg1,
                           logic [7:0] f0, logic [7:0] m0, logic [15:0] rg0, logic [15:0] bg0,
                           bit typed, t_status st);
        t_row r;
        r.bank_set = '{f1, m1, rg1, bg1, f0, m0, rg0, bg0};
        r.typed = typed;
        r.gains = '0;
        r.gains.status = st;
        if (st == ST_ZERO) begin
            r.gains.bank_used = (f1[7:6] == 2'b01);
            r.gains.module_ident = (f1[7:6] == 2'b01) ? m1[7:4] : m0[7:4];
        end
        table_rows.push_back(r);
    endtask

    initial begin
        logic [15:0] rg_set[7];
        logic [15:0] bg_set[7];
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_in = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_RG_TYP;
        i_cfg_data = '0;
        cur_typed = 1'b0;
        cur_gains = '0;
        n_errors = 0;
        n_sets = 0;
        n_results = 0;
        rg_typ_m = RG_TYP_RESET;
        bg_typ_m = BG_TYP_RESET;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // no valid bank in either slot
        add_row(8'h00, 8'hFF, 16'h1234, 16'h5678, 8'h00, 8'hFF, 16'h1, 16'h1, 1, ST_NOVALID);
        add_row(8'hFF, 8'hA5, 16'hFFFF, 16'hFFFF, 8'h80, 8'h5A, 16'hFFFF, 16'hFFFF, 1, ST_NOVALID);
        add_row(8'hBF, 8'h00, 16'h0, 16'h0, 8'h3F, 8'h00, 16'h0, 16'h0, 1, ST_NOVALID);
        // zero ratio on the chosen bank
        add_row(8'h40, 8'hF0, 16'h0, 16'h2ed, 8'h00, 8'h00, 16'h26c, 16'h2ed, 1, ST_ZERO);
        add_row(8'h7F, 8'h30, 16'h26c, 16'h0, 8'h40, 8'h00, 16'h26c, 16'h2ed, 1, ST_ZERO);
        add_row(8'hC0, 8'h00, 16'h26c, 16'h2ed, 8'h55, 8'h9F, 16'h26c, 16'h0, 1, ST_ZERO);
        add_row(8'h00, 8'h00, 16'h26c, 16'h2ed, 8'h40, 8'hE1, 16'h0, 16'h0, 1, ST_ZERO);
        // equal to typical, then each quadrant, bank 1 over bank 0
        add_row(8'h40, 8'h10, 16'h26c, 16'h2ed, 8'h40, 8'h20, 16'h1, 16'h1, 0, ST_OK);
        add_row(8'h40, 8'h21, 16'h200, 16'h200, 8'h00, 8'h00, 16'h0, 16'h0, 0, ST_OK);
        add_row(8'h40, 8'h32, 16'h400, 16'h200, 8'h00, 8'h00, 16'h0, 16'h0, 0, ST_OK);
        add_row(8'h40, 8'h43, 16'h200, 16'h400, 8'h00, 8'h00, 16'h0, 16'h0, 0, ST_OK);
        add_row(8'h40, 8'h54, 16'h300, 16'h500, 8'h00, 8'h00, 16'h0, 16'h0, 0, ST_OK);
        add_row(8'h40, 8'h65, 16'h500, 16'h300, 8'h00, 8'h00, 16'h0, 16'h0, 0, ST_OK);
        // bank 0 quadrants, then a bank 1 row; saturation at the extremes
        add_row(8'h00, 8'h00, 16'h0, 16'h0, 8'h41, 8'h76, 16'h1, 16'h1, 0, ST_OK);
        add_row(8'h00, 8'h00, 16'h0, 16'h0, 8'h42, 8'h87, 16'hFFFF, 16'hFFFF, 0, ST_OK);
        add_row(8'h00, 8'h00, 16'h0, 16'h0, 8'h43, 8'h98, 16'h1, 16'hFFFF, 0, ST_OK);
        add_row(8'h00, 8'h00, 16'h0, 16'h0, 8'h44, 8'hA9, 16'hFFFF, 16'h1, 0, ST_OK);
        add_row(8'h40, 8'hFF, 16'h1, 16'h2ed, 8'h00, 8'h00, 16'h0, 16'h0, 0, ST_OK);

        foreach (table_rows[i])
            send_set(table_rows[i].bank_set, table_rows[i].typed, table_rows[i].gains);
        @(negedge i_clk);
        i_start <= 1'b0;
        cur_typed <= 1'b0;

        rg_set = '{16'd620, 16'd1, 16'hFFFF, 16'd1, 16'hFFFF, 16'd0, 16'd0};
        bg_set = '{16'd749, 16'd1, 16'hFFFF, 16'hFFFF, 16'd1, 16'd0, 16'd0};
        for (int p = 0; p < 7; p++) begin
            wait_drained();
            if (p >= 5) begin
                rg_set[p] = 16'($urandom_range(1, 65535));
                bg_set[p] = 16'($urandom_range(1, 2000));
            end
            cfg_write(CFG_RG_TYP, rg_set[p]);
            cfg_write(CFG_BG_TYP, bg_set[p]);
            for (int k = 0; k < 220; k++)
                send_set(rand_set(), 1'b0, '0);
            @(negedge i_clk);
            i_start <= 1'b0;
        end

        wait_drained();
        $display("bank sets sent %0d, results %0d over 7 typical-ratio settings",
                 n_sets, n_results);
        $display("status ok %0d, no bank %0d, zero ratio %0d, saturated %0d",
                 n_status[0], n_status[1], n_status[2], n_status[3]);
        if (n_errors == 0 && gain_q.size() == 0)
            $display("otp_awb_gain_calc_unit verification clean");
        else
            $display("otp_awb_gain_calc_unit verification failed");
        $finish;
    end

    initial begin
        #20_000_000;
        $display("otp_awb_gain_calc_unit verification failed");
        $finish;
    end

endmodule

// File: otp_awb_gain_calc_unit.f
rtl/otp_pkg.sv
rtl/otp_div_pipe.sv
rtl/otp_front.sv
rtl/otp_awb_gain_calc_unit.sv
rtl/otp_chk.sv
test/tb_otp_awb_gain_calc_unit.sv
